>>> hw/rtl/sdf_pkg.sv
`timescale 1ns / 1ps

package sdf_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned ValueWidthDefault = 32;

  typedef struct packed {
    logic signed [31:0] value;
    logic               end_of_sequence;
  } sdf_in_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic               keep;
    logic               table_overflow;
    logic               last_out;
  } sdf_out_t;

  typedef struct packed {
    logic ins;
    logic clr;
  } sdf_tbl_ctrl_t;

  typedef struct packed {
    logic hit;
    logic full;
  } sdf_tbl_stat_t;

endpackage

>>> hw/rtl/sdf_table.sv
`timescale 1ns / 1ps

module sdf_table import sdf_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault,
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] key_i,
  input  sdf_tbl_ctrl_t          ctrl_i,
  output sdf_tbl_stat_t          stat_o
);

  localparam int unsigned IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(TABLE_DEPTH + 1);

  logic [VALUE_WIDTH-1:0] seen_q [TABLE_DEPTH];
  logic [FillW-1:0]       fill_q, fill_d;
  logic [TABLE_DEPTH-1:0] match;

  // an entry is valid when it lies below the fill count
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cmp
    assign match[i] = (FillW'(i) < fill_q) && (seen_q[i] == key_i);
  end

  assign stat_o.hit  = |match;
  assign stat_o.full = (fill_q == FillW'(TABLE_DEPTH));

  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.clr) begin
      fill_d = '0;
    end else if (ctrl_i.ins) begin
      fill_d = fill_q + FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins) begin
      seen_q[fill_q[IdxW-1:0]] <= key_i;
    end
  end

  a_clr_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clr |=> fill_q == '0)
    else $error("table not emptied after clear");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_no_ins_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.ins |-> !stat_o.full && !stat_o.hit)
    else $error("insert into full table or of a stored key");

endmodule

>>> hw/rtl/stream_duplicate_filter.sv
`timescale 1ns / 1ps

// Duplicate filter: one request per cycle sustained while out_ready_i is not
// held low. A request accepted into the input register is filtered from there
// and its result is captured in the result register once that register is free
// (input register, then result register). The incoming value is compared
// against every stored entry at once; a first occurrence is appended if space
// is left, otherwise it is passed with the overflow flag set. The table empties
// when the request marked end_of_sequence is filtered: its fill count is zeroed
// as its result is registered, so no clearing pass is needed after reset or
// between sequences. Values compare on their low VALUE_WIDTH bits.
module stream_duplicate_filter import sdf_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault,
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sdf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sdf_out_t out_data_o
);

  logic          in_vld_q;
  sdf_in_t       in_q;
  logic          out_vld_q;
  sdf_out_t      out_q, out_d;
  logic          fire;
  logic [VALUE_WIDTH+31:0] key_ext;
  sdf_tbl_ctrl_t tbl_ctrl;
  sdf_tbl_stat_t tbl_stat;

  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  assign key_ext = {{VALUE_WIDTH{1'b0}}, in_q.value};

  assign tbl_ctrl.ins = fire && !tbl_stat.hit && !tbl_stat.full;
  assign tbl_ctrl.clr = fire && in_q.end_of_sequence;

  sdf_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_table (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .key_i (key_ext[VALUE_WIDTH-1:0]),
    .ctrl_i(tbl_ctrl),
    .stat_o(tbl_stat)
  );

  always_comb begin
    out_d.value_out      = in_q.value;
    out_d.keep           = !tbl_stat.hit;
    out_d.table_overflow = !tbl_stat.hit && tbl_stat.full;
    out_d.last_out       = in_q.end_of_sequence;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("filtered request produced no result");

  a_ovf_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.table_overflow |-> out_q.keep)
    else $error("overflow flagged on a dropped request");

  a_no_fire_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> !fire)
    else $error("table updated without a held request");

endmodule

>>> verif/stream_duplicate_filter_test.sv
`timescale 1ns / 1ps

module stream_duplicate_filter_test;
  import sdf_pkg::*;

  localparam int unsigned DEPTH       = TableDepthDefault;
  localparam int          NUM_ITEMS   = 1000;
  localparam int          STALL_LIMIT = 2000;

  class dedup_scoreboard;
    logic [31:0] seen [DEPTH];
    int unsigned fill;
    sdf_out_t    pending [$];
    int          mismatches;
    int          results;
    int          kept;
    int          dropped;
    int          overflows;
    int          sequences;

    function new();
      fill = 0;
      mismatches = 0;
      results = 0;
      kept = 0;
      dropped = 0;
      overflows = 0;
      sequences = 0;
    endfunction

    // filter the request against the seen table and queue the expected result
    function void note_request(sdf_in_t req);
      sdf_out_t exp_res;
      bit       hit;
      hit = 1'b0;
      for (int i = 0; i < int'(fill); i++) begin
        if (seen[i] == req.value) begin
          hit = 1'b1;
        end
      end
      exp_res.value_out      = req.value;
      exp_res.keep           = !hit;
      exp_res.table_overflow = 1'b0;
      exp_res.last_out       = req.end_of_sequence;
      if (!hit) begin
        if (fill < DEPTH) begin
          seen[fill] = req.value;
          fill++;
        end else begin
          exp_res.table_overflow = 1'b1;
        end
      end
      if (req.end_of_sequence) begin
        fill = 0;
      end
      pending.push_back(exp_res);
    endfunction

    function void check_result(sdf_out_t got);
      sdf_out_t exp_res;
      results++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result value=%h keep=%b ovf=%b last=%b", $realtime,
                   got.value_out, got.keep, got.table_overflow, got.last_out);
        end
        return;
      end
      exp_res = pending.pop_front();
      if (got.value_out !== exp_res.value_out || got.keep !== exp_res.keep ||
          got.table_overflow !== exp_res.table_overflow ||
          got.last_out !== exp_res.last_out) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp value=%h keep=%b ovf=%b last=%b", $realtime,
                   exp_res.value_out, exp_res.keep, exp_res.table_overflow,
                   exp_res.last_out);
          $display("%0t:          got value=%h keep=%b ovf=%b last=%b", $realtime,
                   got.value_out, got.keep, got.table_overflow, got.last_out);
        end
      end
      if (exp_res.keep) kept++;
      else dropped++;
      if (exp_res.table_overflow) overflows++;
      if (exp_res.last_out) sequences++;
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  sdf_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  sdf_out_t out_data_o;

  dedup_scoreboard sb = new();
  bit              calm;
  int              sent;
  int              idle_cycles;

  stream_duplicate_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance or after a random gap
  task automatic send_request(logic [31:0] value, logic eos);
    sdf_in_t req;
    int      gap;
    req.value           = value;
    req.end_of_sequence = eos;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent++;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // values from a pool so repeats are common, or random ones with noise; with
  // sweep the distinct pool values are walked in order before random picks
  task automatic send_sequence(int len, int pool_size, bit noise, bit sweep);
    logic [31:0] pool [$];
    logic [31:0] v;
    logic [31:0] base;
    int          r;
    base = $urandom;
    for (int i = 0; i < pool_size; i++) begin
      r = $urandom_range(0, 9);
      if (sweep) begin
        pool.push_back(base + 32'(i));
      end else begin
        case (r)
          0: pool.push_back(32'h8000_0000);
          1: pool.push_back(32'h7fff_ffff);
          2: pool.push_back(32'hffff_ffff);
          3: pool.push_back(32'h0000_0000);
          4: pool.push_back($urandom_range(0, 15));
          default: pool.push_back($urandom);
        endcase
      end
    end
    calm = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      if (sweep && i < pool_size) begin
        v = pool[i];
      end else begin
        v = noise ? 32'($urandom) : pool[$urandom_range(0, pool_size - 1)];
      end
      send_request(v, i == len - 1);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == STALL_LIMIT) begin
          $display("Watchdog: no request or result for %0d cycles", STALL_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      stall = gap_len();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  initial begin
    logic [31:0] dir_vals [];
    logic        dir_last [];
    int          kind;
    int          len;
    int          psz;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    calm        = 1'b0;
    sent        = 0;
    idle_cycles = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes and repeats, one-item sequences, sign bit only difference,
    // repeats across a sequence boundary
    dir_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                 32'h0000_0005, 32'h0000_0005,
                 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                 32'h0000_0001, 32'h8000_0001, 32'h8000_0001, 32'h5555_aaaa};
    dir_last = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                 1'b1, 1'b1,
                 1'b0, 1'b0, 1'b1, 1'b1,
                 1'b0, 1'b0, 1'b0, 1'b1};
    foreach (dir_vals[i]) send_request(dir_vals[i], dir_last[i]);

    while (sent < NUM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        len = $urandom_range(1, 24);
        send_sequence(len, $urandom_range(1, len + 4), 1'b0, 1'b0);
      end else if (kind < 85) begin
        // exceed the table: overflows and unstored values seen again
        psz = $urandom_range(66, 90);
        send_sequence(psz + $urandom_range(4, 30), psz, 1'b0, 1'b1);
      end else if (kind < 90) begin
        // table filled exactly, then only repeats
        send_sequence($urandom_range(90, 120), DEPTH, 1'b0, 1'b1);
      end else begin
        send_sequence($urandom_range(1, 40), 1, 1'b1, 1'b0);
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d requests in %0d sequences: %0d kept, %0d dropped, %0d overflows",
             sent, sb.sequences, sb.kept, sb.dropped, sb.overflows);
    $display("Results checked: %0d, mismatches: %0d", sb.results, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
